FILE: hdl/mlce_pkg.sv
// Shared types and constants for the multi-mode line code encoder.
// No dependencies; imported by every module of the encoder.
`timescale 1ns / 1ps

package mlce_pkg;

    // Line code selection, value of the code_mode register
    localparam logic [2:0] MODE_NRZ        = 3'd0;
    localparam logic [2:0] MODE_MANCH      = 3'd1;
    localparam logic [2:0] MODE_DIFF_MANCH = 3'd2;
    localparam logic [2:0] MODE_PART_RESP  = 3'd3;
    localparam logic [2:0] MODE_AMI        = 3'd4;
    localparam logic [2:0] MODE_2B1Q       = 3'd5;
    localparam logic [2:0] MODE_RZ         = 3'd6;

    // Configuration register map (register index taken from paddr[2])
    localparam int          CFG_ADDR_W    = 3;
    localparam logic        REG_CODE_MODE = 1'b0;

    typedef logic signed [2:0] level_t;

    localparam level_t LVL_P3   = 3'sd3;
    localparam level_t LVL_P1   = 3'sd1;
    localparam level_t LVL_ZERO = 3'sd0;
    localparam level_t LVL_M1   = -3'sd1;
    localparam level_t LVL_M3   = -3'sd3;

    // Output queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    // Levels produced by one input transaction: count is 0, 1 or 2.
    // With one level it sits in lev0; with two, lev0 goes out first.
    typedef struct packed {
        logic [1:0] count;
        level_t     lev0;
        level_t     lev1;
    } sym_pair_t;

    // One queued result
    typedef struct packed {
        level_t level;
        logic   last;
    } oq_entry_t;

endpackage

FILE: hdl/mlce_mapper.sv
// Symbol mapper: turns one accepted data bit into zero, one or two line levels
// and holds the coding state. Depends on mlce_pkg.
`timescale 1ns / 1ps

module mlce_mapper
    import mlce_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      accept,
    input  logic      data_bit,
    input  logic [2:0] code_mode,
    output sym_pair_t pair
);

    logic mark_polarity_reg, mark_polarity_next;
    logic previous_bit_reg, previous_bit_next;
    logic last_level_high_reg, last_level_high_next;
    logic pair_phase_reg, pair_phase_next;
    logic pending_sign_bit_reg, pending_sign_bit_next;

    sym_pair_t pair_raw;
    level_t    final_level;

    always_comb begin
        pair_raw              = '{count: 2'd0, lev0: LVL_ZERO, lev1: LVL_ZERO};
        mark_polarity_next    = mark_polarity_reg;
        pending_sign_bit_next = pending_sign_bit_reg;
        pair_phase_next       = 1'b0;
        unique case (code_mode)
            MODE_NRZ: begin
                pair_raw.count = 2'd1;
                pair_raw.lev0  = data_bit ? LVL_P1 : LVL_M1;
            end
            MODE_MANCH: begin
                pair_raw.count = 2'd2;
                pair_raw.lev0  = data_bit ? LVL_M1 : LVL_P1;
                pair_raw.lev1  = data_bit ? LVL_P1 : LVL_M1;
            end
            MODE_DIFF_MANCH: begin
                // first half is high when the bit matches the last level's sign
                pair_raw.count = 2'd2;
                pair_raw.lev0  = (data_bit == last_level_high_reg) ? LVL_P1 : LVL_M1;
                pair_raw.lev1  = (data_bit == last_level_high_reg) ? LVL_M1 : LVL_P1;
            end
            MODE_PART_RESP: begin
                pair_raw.count = 2'd1;
                pair_raw.lev0  = (data_bit && !previous_bit_reg) ? LVL_P1 : LVL_ZERO;
            end
            MODE_AMI: begin
                pair_raw.count = 2'd1;
                if (data_bit) begin
                    pair_raw.lev0      = mark_polarity_reg ? LVL_P1 : LVL_M1;
                    mark_polarity_next = ~mark_polarity_reg;
                end
            end
            MODE_2B1Q: begin
                if (!pair_phase_reg) begin
                    // hold the first bit of the pair, nothing goes out yet
                    pending_sign_bit_next = data_bit;
                    pair_phase_next       = 1'b1;
                end else begin
                    pair_raw.count = 2'd1;
                    case ({pending_sign_bit_reg, data_bit})
                        2'b11:   pair_raw.lev0 = LVL_P3;
                        2'b10:   pair_raw.lev0 = LVL_P1;
                        2'b01:   pair_raw.lev0 = LVL_M1;
                        default: pair_raw.lev0 = LVL_M3;
                    endcase
                end
            end
            MODE_RZ: begin
                pair_raw.count = 2'd2;
                pair_raw.lev0  = LVL_ZERO;
                pair_raw.lev1  = data_bit ? LVL_P1 : LVL_M1;
            end
            default: begin
                // unused code: drop the bit, only the history advances
            end
        endcase
    end

    assign final_level = (pair_raw.count == 2'd2) ? pair_raw.lev1 : pair_raw.lev0;

    always_comb begin
        previous_bit_next    = data_bit;
        last_level_high_next = last_level_high_reg;
        if (pair_raw.count != 2'd0) begin
            last_level_high_next = !final_level[2] && (final_level != LVL_ZERO);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_polarity_reg    <= 1'b0;
            previous_bit_reg     <= 1'b0;
            last_level_high_reg  <= 1'b0;
            pair_phase_reg       <= 1'b0;
            pending_sign_bit_reg <= 1'b0;
        end else if (accept) begin
            mark_polarity_reg    <= mark_polarity_next;
            previous_bit_reg     <= previous_bit_next;
            last_level_high_reg  <= last_level_high_next;
            pair_phase_reg       <= pair_phase_next;
            pending_sign_bit_reg <= pending_sign_bit_next;
        end
    end

    always_comb begin
        pair = pair_raw;
        if (!accept) begin
            pair.count = 2'd0;
        end
    end

endmodule

FILE: hdl/mlce_outq.sv
// Output queue: takes up to two levels per cycle, hands out one per cycle while out_ready is high.
// Depends on mlce_pkg.
`timescale 1ns / 1ps

module mlce_outq
    import mlce_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  sym_pair_t pair,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output oq_entry_t out_entry
);

    oq_entry_t             entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0]   count_reg, count_next;
    logic [OQ_PTR_W-1:0]   wr_ptr_inc;
    logic                  pop;

    assign room      = (count_reg <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_entry = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    assign wr_ptr_inc  = wr_ptr_reg + OQ_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + OQ_PTR_W'(pair.count);
    assign rd_ptr_next = rd_ptr_reg + OQ_PTR_W'(pop);
    assign count_next  = count_reg + OQ_CNT_W'(pair.count) - OQ_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (pair.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= '{level: pair.lev0, last: (pair.count == 2'd1)};
        end
        if (pair.count == 2'd2) begin
            entry_reg[wr_ptr_inc] <= '{level: pair.lev1, last: 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/multi_mode_line_code_encoder.sv
// Multi-mode line code encoder, top level: APB register, symbol mapper and
// output queue. Depends on mlce_pkg, mlce_mapper and mlce_outq.
// A bit's levels are queued when it is accepted on s_ and leave on m_ in order.
// Throughput: one bit per cycle in one-level codes (NRZ, partial response,
//   AMI, 2B1Q) while m_tready is high; two-level codes are limited by the
//   single level per cycle that m_ delivers from the four-entry queue.
// Reset: synchronous, active-low aresetn clears the mode to NRZ, all coding
//   state and the queue; the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module multi_mode_line_code_encoder
    import mlce_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] data_bit, [7:1] zero

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [2:0] line_level, [7:3] zero
    output logic                  m_tlast,   // last_of_bit

    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [2:0] code_mode_reg;
    logic       cfg_write;
    logic       s_accept;
    logic       q_room;
    sym_pair_t  pair;
    oq_entry_t  head;

    // Configuration: one register, code_mode, at byte address 0.
    // Hold the mode between writes; take only the low three bits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_mode_reg <= MODE_NRZ;
        end else if (cfg_write && (paddr[2] == REG_CODE_MODE)) begin
            code_mode_reg <= pwdata[2:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_CODE_MODE) begin
            prdata = {29'd0, code_mode_reg};
        end
    end

    // Accept a transaction whenever the queue has space for two levels, so
    // input keeps flowing while queued results wait on m_tready.
    assign s_tready = q_room;
    assign s_accept = s_tvalid && s_tready;

    mlce_mapper u_mapper (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .data_bit  (s_tdata[0]),
        .code_mode (code_mode_reg),
        .pair      (pair)
    );

    // Queue the levels of each bit; drain one per transaction on m_.
    mlce_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pair      (pair),
        .room      (q_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (head)
    );

    assign m_tdata = {5'd0, head.level};
    assign m_tlast = head.last;

endmodule

FILE: tb/multi_mode_line_code_encoder_test.sv
// Self-checking testbench for the multi-mode line code encoder: directed and random data bits
// in every line code, random stalls on both streams, and mode changes through the APB port.
// Depends on mlce_pkg and the multi_mode_line_code_encoder RTL.
`timescale 1ns / 1ps

module multi_mode_line_code_encoder_test;
    import mlce_pkg::*;

    // Code 7 selects no line code: the encoder swallows the bit silently
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    // code_mode sits at index 0; index 1 is decoded by paddr[2] and must be ignored
    localparam logic [CFG_ADDR_W-1:0] CODE_MODE_ADDR = {REG_CODE_MODE, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR     = {~REG_CODE_MODE, 2'b00};

    localparam int RANDOM_BITS    = 360;
    localparam int CALM_AFTER     = 300;   // no new idling starts past this many random bits
    localparam int SETTLE_CYCLES  = 4;     // covers a 2B1Q first bit that yields nothing
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        level_t level;
        logic   last;
    } line_symbol_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [0] data_bit, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [2:0] line_level, [7:3] zero
    logic                  m_tlast;        // last_of_bit
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    multi_mode_line_code_encoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Bits waiting for the input stream, and levels the encoder still owes us
    logic         pending_bits[$];
    line_symbol_t levels_due[$];

    // Encoder state as the testbench sees it
    logic [2:0] cur_mode;
    logic       mark_positive;    // next AMI mark is +1
    logic       prev_bit;
    logic       last_level_high;  // last emitted level was above zero
    logic       pair_held;        // first bit of a 2B1Q pair is waiting
    logic       held_bit;

    // Per-cycle handshake flags, sampled at the rising edge
    logic bit_taken = 1'b0;
    logic level_taken = 1'b0;

    logic        calm = 1'b0;     // set for the tail of the run: no new idling starts
    int          feed_gap = 0;
    int          sink_stall = 0;
    int          idle_cycles = 0;
    int unsigned errors = 0;
    int unsigned bits_sent = 0;
    int unsigned levels_checked = 0;
    int unsigned reg_writes = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Queue one level and remember its sign for differential Manchester
    task push_level(input level_t lv, input logic last);
        line_symbol_t sym;
        sym.level = lv;
        sym.last  = last;
        levels_due.push_back(sym);
        last_level_high = (lv > 0);
    endtask

    // Work out the levels that one accepted data bit must produce
    task encode_bit(input logic b);
        level_t lv;
        if (cur_mode != MODE_2B1Q)
            pair_held = 1'b0;
        case (cur_mode)
            MODE_NRZ: begin
                push_level(b ? LVL_P1 : LVL_M1, 1'b1);
            end
            MODE_MANCH: begin
                push_level(b ? LVL_M1 : LVL_P1, 1'b0);
                push_level(b ? LVL_P1 : LVL_M1, 1'b1);
            end
            MODE_DIFF_MANCH: begin
                // a one after a high level, or a zero after one that was not, starts high; otherwise low
                if (last_level_high == b) begin
                    push_level(LVL_P1, 1'b0);
                    push_level(LVL_M1, 1'b1);
                end else begin
                    push_level(LVL_M1, 1'b0);
                    push_level(LVL_P1, 1'b1);
                end
            end
            MODE_PART_RESP: begin
                push_level((b && !prev_bit) ? LVL_P1 : LVL_ZERO, 1'b1);
            end
            MODE_AMI: begin
                if (b) begin
                    push_level(mark_positive ? LVL_P1 : LVL_M1, 1'b1);
                    mark_positive = ~mark_positive;
                end else begin
                    push_level(LVL_ZERO, 1'b1);
                end
            end
            MODE_2B1Q: begin
                if (!pair_held) begin
                    held_bit  = b;
                    pair_held = 1'b1;
                end else begin
                    if (held_bit)
                        lv = b ? LVL_P3 : LVL_P1;
                    else
                        lv = b ? LVL_M1 : LVL_M3;
                    push_level(lv, 1'b1);
                    pair_held = 1'b0;
                end
            end
            MODE_RZ: begin
                push_level(LVL_ZERO, 1'b0);
                push_level(b ? LVL_P1 : LVL_M1, 1'b1);
            end
            default: begin
                // unused code: no level, only the bit history moves
            end
        endcase
        prev_bit = b;
    endtask

    // Input driver: present the next bit once the previous transaction has gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || bit_taken) begin
            if (feed_gap > 0) begin
                feed_gap--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                feed_gap = $urandom_range(0, 14);
                s_tvalid <= 1'b0;
            end else if (pending_bits.size() > 0) begin
                s_tdata  <= {7'b0, pending_bits.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: stall in bursts; no new burst starts during the calm tail
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_stall = $urandom_range(0, 14);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: predict on every accepted bit, check every accepted level, watch for hangs
    always @(posedge aclk) begin
        line_symbol_t want;
        bit_taken   = aresetn && s_tvalid && s_tready;
        level_taken = aresetn && m_tvalid && m_tready;
        if (bit_taken) begin
            encode_bit(s_tdata[0]);
            bits_sent++;
        end
        if (level_taken) begin
            levels_checked++;
            if (levels_due.size() == 0) begin
                $display("%0t: unexpected level, expected none, actual level %0d last %b",
                         $time, $signed(m_tdata[2:0]), m_tlast);
                errors++;
            end else begin
                want = levels_due.pop_front();
                if (m_tdata !== {5'b0, want.level} || m_tlast !== want.last) begin
                    $display("%0t: expected level %0d last %b, actual tdata 0x%h last %b",
                             $time, want.level, want.last, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
        // Any transaction on either stream or the APB port counts as progress
        if (bit_taken || level_taken || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d levels still owed",
                     $time, WATCHDOG_LIMIT, levels_due.size());
            $display("multi_mode_line_code_encoder: mismatch");
            $finish;
        end
    end

    // Hold until every queued bit is in and every owed level is out, then settle.
    // Look at the rising edge, where the driver's outputs have already settled.
    task wait_idle;
        do
            @(posedge aclk);
        while (pending_bits.size() != 0 || s_tvalid || levels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Read code_mode back and compare with the mode the predictor uses
    task read_mode_check;
        logic [31:0] got;
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= CODE_MODE_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {29'b0, cur_mode}) begin
            $display("%0t: expected code_mode readback 0x%h, actual 0x%h",
                     $time, {29'b0, cur_mode}, got);
            errors++;
        end
    endtask

    // Write one register while the encoder is idle, then confirm the mode
    task write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_CODE_MODE)
            cur_mode = value[2:0];   // only the low three bits are kept
        reg_writes++;
        @(negedge aclk);
        read_mode_check();
    endtask

    // Queue a bit pattern, lowest bit first
    task queue_bits(input logic [31:0] pattern, input int count);
        for (int k = 0; k < count; k++)
            pending_bits.push_back(pattern[k]);
    endtask

    initial begin
        int          nbits;
        int          random_bits;
        logic [2:0]  m;
        logic [31:0] v;

        cur_mode        = MODE_NRZ;
        mark_positive   = 1'b0;
        prev_bit        = 1'b0;
        last_level_high = 1'b0;
        pair_held       = 1'b0;
        held_bit        = 1'b0;
        random_bits     = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        read_mode_check();

        // Directed: NRZ straight out of reset, zero then one
        queue_bits(32'b10, 2);
        // Manchester, with junk above the mode field to prove the masking
        write_reg(CODE_MODE_ADDR, 32'hFFFF_FFF8 | {29'b0, MODE_MANCH});
        queue_bits(32'b01, 2);
        // Differential Manchester: ones after both level signs, then two zeros
        write_reg(CODE_MODE_ADDR, {29'b0, MODE_DIFF_MANCH});
        queue_bits(32'b0011, 4);
        // Partial response: a rise, a held one, a fall, a rise
        write_reg(CODE_MODE_ADDR, {29'b0, MODE_PART_RESP});
        queue_bits(32'b1011, 4);
        // AMI: marks alternate, a space in between
        write_reg(CODE_MODE_ADDR, {29'b0, MODE_AMI});
        queue_bits(32'b1101, 4);
        // 2B1Q: pairs 11, 10, 01, then hold a first bit across a write to the spare slot
        write_reg(CODE_MODE_ADDR, {29'b0, MODE_2B1Q});
        queue_bits(32'b0100111, 7);
        write_reg(SPARE_ADDR, {29'b0, MODE_UNUSED});
        // finish pair 00, then hold a one and drop it by leaving 2B1Q
        queue_bits(32'b10, 2);
        write_reg(CODE_MODE_ADDR, {29'b0, MODE_RZ});
        queue_bits(32'b01, 2);
        // Unused code swallows the bits
        write_reg(CODE_MODE_ADDR, {29'b0, MODE_UNUSED});
        queue_bits(32'b01, 2);

        // Random phases: random mode, random bits, random stalls
        while (random_bits < RANDOM_BITS) begin
            m = 3'($urandom_range(0, 7));
            v = ($urandom & 32'hFFFF_FFF8) | {29'b0, m};
            if ($urandom_range(0, 5) == 0)
                write_reg(SPARE_ADDR, $urandom);
            write_reg(CODE_MODE_ADDR, v);
            nbits = $urandom_range(6, 40);
            // mostly whole 2B1Q pairs; an odd count leaves a first bit to be dropped
            if (m == MODE_2B1Q && $urandom_range(0, 3) != 0)
                nbits = nbits & ~1;
            for (int k = 0; k < nbits; k++)
                pending_bits.push_back(1'($urandom_range(0, 1)));
            random_bits += nbits;
            if (random_bits >= CALM_AFTER)
                calm = 1'b1;
        end

        wait_idle();
        repeat (10) @(negedge aclk);
        $display("Encoded %0d data bits in all line codes with %0d register writes;",
                 bits_sent, reg_writes);
        $display("checked %0d line levels under random input gaps and output stalls.",
                 levels_checked);
        if (errors == 0 && levels_due.size() == 0)
            $display("multi_mode_line_code_encoder: match");
        else
            $display("multi_mode_line_code_encoder: mismatch");
        $finish;
    end

endmodule
